@@ rtl/rtc_pkg.sv @@
// rtc_pkg: shared constants for the textured wall column raycaster
// depends on nothing; used by raycast_textured_column
package rtc_pkg;

    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int TEX_SIZE_DEF      = 64;
    localparam int TEX_COUNT         = 4;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] HALF_MASK = 24'd8355711;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CEILING = 2'd0,
        CFG_FLOOR   = 2'd1,
        CFG_OFFSET  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } t_cmd;

endpackage

@@ rtl/raycast_textured_column.sv @@
// raycast_textured_column: texel store plus per-column wall/ceiling/floor pixel generator
// depends on rtc_pkg; single module, one shared restoring divider
// texel load: accepted while idle and written to the texel memory, no output
// column: accept, then three divisions on the shared divider for line height,
//   texture-y start and step, then per row a memory read (S_RD) and then an output
//   request (S_OUT) for SCREEN_HEIGHT rows; S_OUT holds while m_axis_tready is low
// reset (synchronous, active low) clears the sequencer and config registers; the texel
//   memory is not cleared
module raycast_textured_column #(
    parameter int SCREEN_HEIGHT = rtc_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_SIZE      = rtc_pkg::TEX_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rtc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // column[9:0], perp_depth[33:10], side[34], step_x_neg[35], step_y_neg[36],
    // ray_dir_x[54:37], ray_dir_y[72:55], pos_x[96:73], pos_y[120:97],
    // texel_addr[134:121], texel_color[158:135], zero[159]
    input  logic [rtc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tuser,  // cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_column[9:0], pixel_row[15:10], pixel_color[39:16]
    output logic [rtc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import rtc_pkg::*;

    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int TB    = $clog2(TEX_SIZE);
    localparam int DW    = RW + 17;
    localparam int CW    = $clog2(DW + 1);
    localparam int AW    = 2 + 2 * TB;
    localparam int DEPTH = TEX_COUNT * TEX_SIZE * TEX_SIZE;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        OP_LH   = 2'd0,
        OP_N0   = 2'd1,
        OP_STEP = 2'd2
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [23:0] r_ceil, r_floor;
    logic signed [6:0] r_off;

    logic [23:0] mem [DEPTH];
    logic [23:0] r_rd;

    // latched column fields
    logic [9:0]  r_col;
    logic [23:0] r_dist;
    logic        r_side;
    logic [1:0]  r_id;
    logic        r_mirror;
    logic [15:0] r_pos_lo;
    logic signed [17:0] r_dir;
    logic [15:0] r_prod;

    // divider
    logic [DW-1:0] r_dvd, r_quo;
    logic [23:0]   r_rem, r_dvs;
    logic [CW-1:0] r_cnt;

    logic [DW-1:0] r_lh;
    logic signed [19:0] r_q;
    logic [23:0]   r_r;
    logic [TB:0]   r_qs;
    logic [23:0]   r_rs;
    logic [RW-1:0] r_row;

    // input unpack
    logic [9:0]  w_in_col;
    logic [23:0] w_in_dist, w_dist;
    logic        w_in_side, w_sxn, w_syn;
    logic signed [17:0] w_rdx, w_rdy;
    logic [23:0] w_posx, w_posy;
    logic [13:0] w_taddr;
    logic [23:0] w_tcolor;
    logic        w_acc;

    assign w_in_col  = s_axis_tdata[9:0];
    assign w_in_dist = s_axis_tdata[33:10];
    assign w_in_side = s_axis_tdata[34];
    assign w_sxn     = s_axis_tdata[35];
    assign w_syn     = s_axis_tdata[36];
    assign w_rdx     = s_axis_tdata[54:37];
    assign w_rdy     = s_axis_tdata[72:55];
    assign w_posx    = s_axis_tdata[96:73];
    assign w_posy    = s_axis_tdata[120:97];
    assign w_taddr   = s_axis_tdata[134:121];
    assign w_tcolor  = s_axis_tdata[158:135];
    assign w_dist    = (w_in_dist == 24'd0) ? 24'd1 : w_in_dist;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // divider step
    logic [24:0]   w_trial;
    logic          w_ge;
    logic [23:0]   w_rem_n;
    logic [DW-1:0] w_quo_n;
    logic          w_div_last;

    assign w_trial    = {r_rem, r_dvd[DW-1]};
    assign w_ge       = w_trial >= {1'b0, r_dvs};
    assign w_rem_n    = w_ge ? 24'(w_trial - {1'b0, r_dvs}) : w_trial[23:0];
    assign w_quo_n    = {r_quo[DW-2:0], w_ge};
    assign w_div_last = (r_cnt == CW'(DW - 1));

    // m0 = view_offset - SCREEN_HEIGHT/2 for the first row
    logic signed [7:0] w_m0;
    logic [7:0]        w_m0_abs;
    assign w_m0     = 8'(r_off) - 8'(SCREEN_HEIGHT / 2);
    assign w_m0_abs = w_m0[7] ? 8'(-w_m0) : w_m0;

    // wall span bounds, left unclamped since only rows in range are compared
    logic signed [25:0] w_half, w_start, w_end, w_y;
    assign w_half  = $signed(26'(r_lh >> 1));
    assign w_start = 26'(SCREEN_HEIGHT / 2) - 26'(r_off) - w_half;
    assign w_end   = 26'(SCREEN_HEIGHT / 2) - 26'(r_off) + w_half;
    assign w_y     = $signed(26'(r_row));

    // texel address
    logic signed [19:0] w_t;
    logic [TB-1:0] w_ty, w_tx;
    logic [15:0]   w_frac;
    logic [AW-1:0] w_rd_addr;
    logic          w_lh_zero;

    assign w_lh_zero = (r_lh == '0);
    assign w_t       = r_q + 20'(TEX_SIZE / 2);
    always_comb begin
        priority if (w_lh_zero || w_t < 0) begin
            w_ty = '0;
        end else if (w_t > 20'(TEX_SIZE - 1)) begin
            w_ty = TB'(TEX_SIZE - 1);
        end else begin
            w_ty = w_t[TB-1:0];
        end
    end
    assign w_frac    = r_pos_lo + r_prod;
    assign w_tx      = r_mirror ? ~w_frac[15 -: TB] : w_frac[15 -: TB];
    assign w_rd_addr = {r_id, w_ty, w_tx};

    logic [AW-1:0] w_ld_addr;
    assign w_ld_addr = AW'(w_taddr);

    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tuser == CMD_LOAD && 32'(w_taddr) < DEPTH) begin
            mem[w_ld_addr] <= w_tcolor;
        end
        r_rd <= mem[w_rd_addr];
    end

    logic signed [41:0] w_prod;
    assign w_prod = $signed({1'b0, r_dist}) * r_dir;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[31:16];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceil  <= '0;
            r_floor <= '0;
            r_off   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CEILING: r_ceil  <= i_cfg_data;
                CFG_FLOOR:   r_floor <= i_cfg_data;
                CFG_OFFSET:  r_off   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic w_row_last;
    assign w_row_last = (r_row == RW'(SCREEN_HEIGHT - 1));

    logic [23:0] w_rsum;
    assign w_rsum = r_r + r_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LH;
            r_cnt   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && s_axis_tuser == CMD_DRAW) begin
                        r_col    <= w_in_col;
                        r_dist   <= w_dist;
                        r_side   <= w_in_side;
                        r_id     <= w_in_side ? (w_syn ? 2'd0 : 2'd1)
                                              : (w_sxn ? 2'd2 : 2'd3);
                        r_mirror <= w_in_side ? (w_rdy < 0) : (w_rdx > 0);
                        r_pos_lo <= w_in_side ? w_posx[15:0] : w_posy[15:0];
                        r_dir    <= w_in_side ? w_rdx : w_rdy;
                        r_dvd    <= DW'(SCREEN_HEIGHT * 65536);
                        r_dvs    <= w_dist;
                        r_rem    <= '0;
                        r_quo    <= '0;
                        r_cnt    <= '0;
                        r_op     <= OP_LH;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= r_dvd << 1;
                    r_rem <= w_rem_n;
                    r_quo <= w_quo_n;
                    r_cnt <= r_cnt + 1'b1;
                    if (w_div_last) begin
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= '0;
                        unique case (r_op)
                            OP_LH: begin
                                r_lh  <= w_quo_n;
                                r_dvd <= DW'(32'(w_m0_abs) << TB);
                                r_dvs <= 24'(w_quo_n);
                                r_op  <= OP_N0;
                            end
                            OP_N0: begin
                                // floor division of a possibly negative numerator
                                if (!w_m0[7] || w_rem_n == 24'd0) begin
                                    r_q <= w_m0[7] ? -20'(w_quo_n) : 20'(w_quo_n);
                                    r_r <= '0;
                                    if (!w_m0[7]) begin
                                        r_r <= w_rem_n;
                                    end
                                end else begin
                                    r_q <= -20'(w_quo_n) - 20'd1;
                                    r_r <= 24'(r_lh) - w_rem_n;
                                end
                                r_dvd <= DW'(TEX_SIZE);
                                r_op  <= OP_STEP;
                            end
                            OP_STEP: begin
                                r_qs    <= w_quo_n[TB:0];
                                r_rs    <= w_rem_n;
                                r_row   <= '0;
                                r_state <= S_RD;
                            end
                            default: r_op <= OP_LH;
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (w_rsum >= 24'(r_lh)) begin
                            r_r <= w_rsum - 24'(r_lh);
                            r_q <= r_q + 20'(r_qs) + 20'd1;
                        end else begin
                            r_r <= w_rsum;
                            r_q <= r_q + 20'(r_qs);
                        end
                        r_row   <= r_row + 1'b1;
                        r_state <= w_row_last ? S_IDLE : S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [23:0] w_color;
    always_comb begin
        priority if (w_y < w_start) begin
            w_color = r_ceil;
        end else if (w_y <= w_end) begin
            w_color = r_side ? ((r_rd >> 1) & HALF_MASK) : r_rd;
        end else begin
            w_color = r_floor;
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {w_color, 6'(r_row), r_col};
    assign m_axis_tlast  = w_row_last;

endmodule
